>>> sv/ssl_pkg.sv
// Shared types and codes for the sorted set block.
// No dependencies; used by sorted_set_insert_remove_list_top.
package ssl_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int MAX_CELLS    = 16;
	localparam int VAL_W        = 32;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_LIST   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_DONE   = 3'd0,
		ST_DUP    = 3'd1,
		ST_ABSENT = 3'd2,
		ST_FULL   = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_EMIT,
		S_LIST_RD,
		S_LIST_OUT
	} state_t;

endpackage

>>> sv/sorted_set_insert_remove_list_top.sv
// Channel | dir | handshake            | word
// req     | in  | req_valid/req_ready  | action, value
// rsp     | out | rsp_valid/rsp_ready  | status, position, item_value, last
//
// Insert/remove: a linear search over the stored row (a read and a compare state per
// entry, one RAM read port and one comparator), a decide state, then an entry-by-entry
// shift (a read and a write state per moved entry, then the insert value is placed)
// and an emit state that posts the result.
// List: a read and an output state per stored entry. req_ready is high only in idle.
// Reset clears the count and control; the value RAM needs no clearing.
// A stalled rsp holds the sequencer at its next result.
// Depends on ssl_pkg and ssl_ram.
module sorted_set_insert_remove_list_top
	import ssl_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  logic [1:0]              action,
	input  logic signed [VAL_W-1:0] value,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output logic [2:0]              status,
	output logic [3:0]              position,
	output logic signed [VAL_W-1:0] item_value,
	output logic                    last
);

	localparam int CELLS = (CAPACITY < MAX_CELLS) ? CAPACITY : MAX_CELLS;
	localparam int IDX_W = $clog2(CELLS);
	localparam int CNT_W = $clog2(CELLS + 1);

	state_t                  state_q, state_d;
	action_t                 act_q, act_d;
	logic signed [VAL_W-1:0] val_q, val_d;
	logic [CNT_W-1:0]        idx_q, idx_d;
	logic [CNT_W-1:0]        slot_q, slot_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic                    found_q, found_d;
	status_t                 res_q, res_d;

	logic                    ovalid_q, ovalid_d;
	status_t                 ostat_q, ostat_d;
	logic [3:0]              opos_q, opos_d;
	logic signed [VAL_W-1:0] oval_q, oval_d;
	logic                    olast_q, olast_d;

	logic                    we;
	logic [IDX_W-1:0]        waddr;
	logic [VAL_W-1:0]        wdata;
	logic [IDX_W-1:0]        raddr;
	logic [VAL_W-1:0]        rdata;
	logic signed [VAL_W-1:0] rval;
	logic                    out_free;
	logic [CNT_W-1:0]        idx_inc;
	logic [CNT_W-1:0]        idx_dec;

	ssl_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rval     = $signed(rdata);
	assign out_free = !ovalid_q || rsp_ready;
	assign idx_inc  = CNT_W'(idx_q + 1'b1);
	assign idx_dec  = CNT_W'(idx_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_ff @(posedge clk) begin
		act_q   <= act_d;
		val_q   <= val_d;
		idx_q   <= idx_d;
		slot_q  <= slot_d;
		found_q <= found_d;
		res_q   <= res_d;
		ostat_q <= ostat_d;
		opos_q  <= opos_d;
		oval_q  <= oval_d;
		olast_q <= olast_d;
	end

	always_comb begin
		state_d  = state_q;
		act_d    = act_q;
		val_d    = val_q;
		idx_d    = idx_q;
		slot_d   = slot_q;
		cnt_d    = cnt_q;
		found_d  = found_q;
		res_d    = res_q;
		ovalid_d = ovalid_q && !rsp_ready;
		ostat_d  = ostat_q;
		opos_d   = opos_q;
		oval_d   = oval_q;
		olast_d  = olast_q;
		we       = 1'b0;
		waddr    = idx_q[IDX_W-1:0];
		wdata    = rdata;
		raddr    = idx_q[IDX_W-1:0];
		req_ready = 1'b0;

		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					act_d   = action_t'(action);
					val_d   = value;
					idx_d   = '0;
					found_d = 1'b0;
					case (action_t'(action))
						ACT_INSERT, ACT_REMOVE: state_d = S_SRCH_RD;
						ACT_LIST: begin
							if (cnt_q == '0) begin
								res_d   = ST_EMPTY;
								val_d   = '0;
								state_d = S_EMIT;
							end else begin
								state_d = S_LIST_RD;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end

			S_SRCH_RD: begin
				if (idx_q == cnt_q) begin
					slot_d  = idx_q;
					state_d = S_DECIDE;
				end else begin
					state_d = S_SRCH_CMP;
				end
			end

			// one compare per entry: stop at the first entry not below the key
			S_SRCH_CMP: begin
				if (rval == val_q) begin
					found_d = 1'b1;
					slot_d  = idx_q;
					state_d = S_DECIDE;
				end else if (rval < val_q) begin
					idx_d   = idx_inc;
					state_d = S_SRCH_RD;
				end else begin
					slot_d  = idx_q;
					state_d = S_DECIDE;
				end
			end

			S_DECIDE: begin
				if (act_q == ACT_INSERT) begin
					if (found_q) begin
						res_d   = ST_DUP;
						state_d = S_EMIT;
					end else if (cnt_q == CNT_W'(CELLS)) begin
						res_d   = ST_FULL;
						state_d = S_EMIT;
					end else begin
						idx_d   = cnt_q;
						state_d = S_SHIFT_RD;
					end
				end else begin
					if (!found_q) begin
						res_d   = ST_ABSENT;
						state_d = S_EMIT;
					end else begin
						idx_d   = slot_q;
						state_d = S_SHIFT_RD;
					end
				end
			end

			// insert walks down from the top, remove walks up from the hole
			S_SHIFT_RD: begin
				if (act_q == ACT_INSERT) begin
					if (idx_q == slot_q) begin
						we      = 1'b1;
						waddr   = slot_q[IDX_W-1:0];
						wdata   = val_q;
						cnt_d   = CNT_W'(cnt_q + 1'b1);
						res_d   = ST_DONE;
						state_d = S_EMIT;
					end else begin
						raddr   = idx_dec[IDX_W-1:0];
						state_d = S_SHIFT_WR;
					end
				end else begin
					if (idx_inc == cnt_q) begin
						cnt_d   = CNT_W'(cnt_q - 1'b1);
						res_d   = ST_DONE;
						state_d = S_EMIT;
					end else begin
						raddr   = idx_inc[IDX_W-1:0];
						state_d = S_SHIFT_WR;
					end
				end
			end

			S_SHIFT_WR: begin
				we      = 1'b1;
				waddr   = idx_q[IDX_W-1:0];
				wdata   = rdata;
				idx_d   = (act_q == ACT_INSERT) ? idx_dec : idx_inc;
				state_d = S_SHIFT_RD;
			end

			S_EMIT: begin
				if (out_free) begin
					ovalid_d = 1'b1;
					ostat_d  = res_q;
					opos_d   = '0;
					oval_d   = val_q;
					olast_d  = 1'b1;
					state_d  = S_IDLE;
				end
			end

			S_LIST_RD: begin
				state_d = S_LIST_OUT;
			end

			// raddr stays on idx, so rdata holds while the output stalls
			S_LIST_OUT: begin
				if (out_free) begin
					ovalid_d = 1'b1;
					ostat_d  = ST_DONE;
					opos_d   = 4'(idx_q);
					oval_d   = rval;
					olast_d  = (idx_inc == cnt_q);
					if (idx_inc == cnt_q) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_inc;
						state_d = S_LIST_RD;
					end
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	assign rsp_valid  = ovalid_q;
	assign status     = ostat_q;
	assign position   = opos_q;
	assign item_value = oval_q;
	assign last       = olast_q;

endmodule

>>> sv/ssl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
